/* sv/pcw_pkg.sv */
// pcw_pkg: shared types, codes and constants for the png chunk walker
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps

package pcw_pkg;

    // default width of the running byte offset
    localparam int OFFSET_BITS_DEF = 40;
    // width of the reported offsets
    localparam int OUT_OFS_BITS    = 40;
    // signature length in bytes
    localparam int SIG_LEN         = 8;
    // required IHDR data length
    localparam logic [31:0] IHDR_LEN  = 32'd13;
    // chunk type words, big-endian ascii
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // item kind codes
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    // parse phase
    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5
    } t_phase;

    // outcome codes
    typedef enum logic [2:0] {
        OC_IEND         = 3'd0,
        OC_EOF          = 3'd1,
        OC_BAD_IHDR_LEN = 3'd2,
        OC_BAD_DIMS     = 3'd3,
        OC_LEN_TOO_BIG  = 3'd4,
        OC_EOF_TYPE     = 3'd5,
        OC_EOF_DATA     = 3'd6,
        OC_EOF_CRC      = 3'd7
    } t_outcome;

    // one input word
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_item;

    // one result word, first field in the highest bits when packed in tdata
    typedef struct packed {
        logic [OUT_OFS_BITS-1:0] overlay_length;
        logic [OUT_OFS_BITS-1:0] overlay_offset;
        logic                    overlay_present;
        logic                    detected;
        t_outcome                outcome;
    } t_result;

endpackage

/* sv/pcw_in_stage.sv */
// pcw_in_stage: input register for one word of the byte stream
// depends on pcw_pkg
`timescale 1ns / 1ps

module pcw_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pcw_pkg::t_item i_item,
    output logic          o_valid,
    output pcw_pkg::t_item o_item,
    input  logic          i_take
);

    logic           r_valid;
    pcw_pkg::t_item r_item;

    // refill whenever empty or the held word is consumed this cycle
    assign o_ready = !r_valid || i_take;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* sv/pcw_walker.sv */
// pcw_walker: chunk delimiting state and end-of-file result logic
// depends on pcw_pkg
`timescale 1ns / 1ps

module pcw_walker #(
    parameter int OFFSET_BITS = pcw_pkg::OFFSET_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  pcw_pkg::t_item   i_item,
    input  logic             i_flag,
    output logic             o_res_load,
    output pcw_pkg::t_result o_result
);

    localparam logic [OFFSET_BITS-1:0] SIG_OFS = OFFSET_BITS'(pcw_pkg::SIG_LEN);

    pcw_pkg::t_phase   r_phase,  n_phase;
    logic [2:0]        r_fcnt,   n_fcnt;
    logic [31:0]       r_len,    n_len;
    logic [30:0]       r_left,   n_left;
    logic [31:0]       r_type,   n_type;
    logic [63:0]       r_dims,   n_dims;
    logic [OFFSET_BITS-1:0] r_ofs, n_ofs;
    pcw_pkg::t_outcome r_stop_oc, n_stop_oc;
    logic [OFFSET_BITS-1:0] r_stop_ofs, n_stop_ofs;

    logic [7:0]        b;
    logic [31:0]       sh_len;
    logic [31:0]       sh_type;
    logic [30:0]       consumed;
    logic [30:0]       left_dec;
    logic [OFFSET_BITS-1:0] ofs_inc;
    logic [OFFSET_BITS:0]   ofs_diff;
    pcw_pkg::t_outcome code;
    logic              det;
    logic              present;

    assign b        = i_item.data_byte;
    assign sh_len   = {r_len[23:0], b};
    assign sh_type  = {r_type[23:0], b};
    assign consumed = r_len[30:0] - r_left;
    assign left_dec = r_left - 31'd1;
    // saturating offset count
    assign ofs_inc  = (r_ofs != {OFFSET_BITS{1'b1}}) ? r_ofs + 1'b1 : r_ofs;

    // end of chunk data: IHDR sanity, else on to the crc
    function automatic logic [3:0] data_end(input logic [31:0] typ, input logic [31:0] len,
                                           input logic [63:0] dims);
        logic [31:0] w;
        logic [31:0] h;
        logic [3:0]  res;
        w   = dims[63:32];
        h   = dims[31:0];
        res = {1'b0, pcw_pkg::OC_IEND};
        if (typ == pcw_pkg::TYPE_IHDR) begin
            if (len != pcw_pkg::IHDR_LEN) begin
                res = {1'b1, pcw_pkg::OC_BAD_IHDR_LEN};
            end else if (w == 32'd0 || h == 32'd0 || w[31] || h[31]) begin
                res = {1'b1, pcw_pkg::OC_BAD_DIMS};
            end
        end
        return res;
    endfunction

    // next state for one file byte, or a clear after end of file
    always_comb begin
        logic [3:0] de;
        n_phase    = r_phase;
        n_fcnt     = r_fcnt;
        n_len      = r_len;
        n_left     = r_left;
        n_type     = r_type;
        n_dims     = r_dims;
        n_ofs      = r_ofs;
        n_stop_oc  = r_stop_oc;
        n_stop_ofs = r_stop_ofs;
        de         = 4'd0;
        if (i_take && i_item.kind == pcw_pkg::KIND_EOF) begin
            n_phase    = pcw_pkg::PH_SIG;
            n_fcnt     = 3'd0;
            n_len      = 32'd0;
            n_left     = 31'd0;
            n_type     = 32'd0;
            n_dims     = 64'd0;
            n_ofs      = '0;
            n_stop_oc  = pcw_pkg::OC_EOF;
            n_stop_ofs = SIG_OFS;
        end else if (i_take) begin
            n_ofs = ofs_inc;
            case (r_phase)
                pcw_pkg::PH_SIG: begin
                    n_fcnt = r_fcnt + 3'd1;
                    if (r_fcnt == 3'd7) begin
                        n_phase = pcw_pkg::PH_LEN;
                        n_fcnt  = 3'd0;
                        n_len   = 32'd0;
                    end
                end
                pcw_pkg::PH_LEN: begin
                    n_len  = sh_len;
                    n_fcnt = r_fcnt + 3'd1;
                    if (r_fcnt == 3'd3) begin
                        n_stop_ofs = ofs_inc;
                        n_fcnt     = 3'd0;
                        if (sh_len[31]) begin
                            n_stop_oc = pcw_pkg::OC_LEN_TOO_BIG;
                            n_phase   = pcw_pkg::PH_DONE;
                        end else begin
                            n_left  = sh_len[30:0];
                            n_type  = 32'd0;
                            n_phase = pcw_pkg::PH_TYPE;
                        end
                    end
                end
                pcw_pkg::PH_TYPE: begin
                    n_type = sh_type;
                    n_fcnt = r_fcnt + 3'd1;
                    if (r_fcnt == 3'd3) begin
                        n_stop_ofs = ofs_inc;
                        n_fcnt     = 3'd0;
                        n_dims     = 64'd0;
                        if (r_len == 32'd0) begin
                            de = data_end(sh_type, r_len, r_dims);
                            if (de[3]) begin
                                n_stop_oc = pcw_pkg::t_outcome'(de[2:0]);
                                n_phase   = pcw_pkg::PH_DONE;
                            end else begin
                                n_phase = pcw_pkg::PH_CRC;
                            end
                        end else begin
                            n_phase = pcw_pkg::PH_DATA;
                        end
                    end
                end
                pcw_pkg::PH_DATA: begin
                    // the first eight data bytes feed the dimension word
                    if (consumed[30:3] == 28'd0) begin
                        n_dims = {r_dims[55:0], b};
                    end
                    n_left = left_dec;
                    if (left_dec == 31'd0) begin
                        n_stop_ofs = ofs_inc;
                        de = data_end(r_type, r_len, r_dims);
                        if (de[3]) begin
                            n_stop_oc = pcw_pkg::t_outcome'(de[2:0]);
                            n_phase   = pcw_pkg::PH_DONE;
                        end else begin
                            n_phase = pcw_pkg::PH_CRC;
                            n_fcnt  = 3'd0;
                        end
                    end
                end
                pcw_pkg::PH_CRC: begin
                    n_fcnt = r_fcnt + 3'd1;
                    if (r_fcnt == 3'd3) begin
                        n_stop_ofs = ofs_inc;
                        n_fcnt     = 3'd0;
                        if (r_type == pcw_pkg::TYPE_IEND) begin
                            n_stop_oc = pcw_pkg::OC_IEND;
                            n_phase   = pcw_pkg::PH_DONE;
                        end else begin
                            n_phase = pcw_pkg::PH_LEN;
                            n_len   = 32'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= pcw_pkg::PH_SIG;
            r_fcnt     <= 3'd0;
            r_len      <= 32'd0;
            r_left     <= 31'd0;
            r_type     <= 32'd0;
            r_dims     <= 64'd0;
            r_ofs      <= '0;
            r_stop_oc  <= pcw_pkg::OC_EOF;
            r_stop_ofs <= SIG_OFS;
        end else begin
            r_phase    <= n_phase;
            r_fcnt     <= n_fcnt;
            r_len      <= n_len;
            r_left     <= n_left;
            r_type     <= n_type;
            r_dims     <= n_dims;
            r_ofs      <= n_ofs;
            r_stop_oc  <= n_stop_oc;
            r_stop_ofs <= n_stop_ofs;
        end
    end

    // end-of-file outcome from the current phase
    always_comb begin
        case (r_phase)
            pcw_pkg::PH_TYPE: code = pcw_pkg::OC_EOF_TYPE;
            pcw_pkg::PH_DATA: code = pcw_pkg::OC_EOF_DATA;
            pcw_pkg::PH_CRC:  code = pcw_pkg::OC_EOF_CRC;
            pcw_pkg::PH_DONE: code = r_stop_oc;
            default:          code = pcw_pkg::OC_EOF;
        endcase
    end

    // overlay: bytes beyond the stop offset, suppressed by a detection
    assign ofs_diff = {1'b0, r_ofs} - {1'b0, r_stop_ofs};
    assign det      = (code >= pcw_pkg::OC_LEN_TOO_BIG) && i_flag;
    assign present  = !det && !ofs_diff[OFFSET_BITS] && (ofs_diff[OFFSET_BITS-1:0] != '0);

    assign o_res_load               = i_take && (i_item.kind == pcw_pkg::KIND_EOF);
    assign o_result.outcome         = code;
    assign o_result.detected        = det;
    assign o_result.overlay_present = present;
    assign o_result.overlay_offset  = pcw_pkg::OUT_OFS_BITS'(r_stop_ofs);
    assign o_result.overlay_length  = present ?
        pcw_pkg::OUT_OFS_BITS'(ofs_diff[OFFSET_BITS-1:0]) : '0;

    // an end-of-file word always leaves the walker at its start
    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |=> (r_phase == pcw_pkg::PH_SIG && r_ofs == '0))
        else $error("walker not cleared after end of file");

    // once past the signature the stop offset never runs ahead of the byte count
    a_stop_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != pcw_pkg::PH_SIG) |-> (r_stop_ofs <= r_ofs))
        else $error("stop offset beyond byte offset");

    // the data phase is only entered with data still to come
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pcw_pkg::PH_DATA) |-> (r_left != 31'd0))
        else $error("data phase with no data left");

endmodule

/* sv/pcw_out_stage.sv */
// pcw_out_stage: result register towards the master side
// depends on pcw_pkg
`timescale 1ns / 1ps

module pcw_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pcw_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output pcw_pkg::t_result o_result
);

    logic             r_valid;
    pcw_pkg::t_result r_result;

    // free when empty or the held word leaves this cycle
    assign o_can_load = !r_valid || i_ready;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* sv/png_chunk_walker.sv */
// png_chunk_walker: top level, input register, walker, result register, config register
// depends on pcw_pkg, pcw_in_stage, pcw_walker, pcw_out_stage
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata: data_byte; tuser: kind
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: outcome..overlay_length
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_data: flag_broken_media
//
// one word per cycle sustained while the result register has room; each byte costs one
// offset increment and compare in the walker, end of file one offset subtract into the
// result register, which raises m_axis_tvalid when loaded
// a stalled result holds the next end-of-file word in the input register, and the input
// with it; bytes ahead of that word are never held up
// synchronous active-low reset; config writes are always accepted
`timescale 1ns / 1ps

module png_chunk_walker #(
    parameter int OFFSET_BITS = pcw_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [2:0] outcome, [3] detected, [4] overlay_present,
                                        // [44:5] overlay_offset, [84:45] overlay_length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // flag_broken_media
);

    pcw_pkg::t_item   s_item;
    pcw_pkg::t_item   held_item;
    pcw_pkg::t_result walk_result;
    pcw_pkg::t_result out_result;
    logic             held_valid;
    logic             take;
    logic             res_load;
    logic             out_free;
    logic             r_flag;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_flag <= i_cfg_data;
        end
    end

    assign s_item.kind      = s_axis_tuser;
    assign s_item.data_byte = s_axis_tdata;

    pcw_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (take)
    );

    // bytes always advance, end of file waits for room in the result register
    assign take = held_valid && (held_item.kind == pcw_pkg::KIND_BYTE || out_free);

    pcw_walker #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (held_item),
        .i_flag     (r_flag),
        .o_res_load (res_load),
        .o_result   (walk_result)
    );

    pcw_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_load),
        .i_result   (walk_result),
        .o_can_load (out_free),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_result)
    );

    assign m_axis_tdata = {3'b000, out_result};

endmodule

/* test/tb_png_chunk_walker.sv */
// tb_png_chunk_walker: self-checking bench for the png chunk walker
// directed files from a table, then random files under several idle and stall mixes
// depends on pcw_pkg and png_chunk_walker
`timescale 1ns / 1ps

module tb_png_chunk_walker;

    localparam int          OFS_W        = pcw_pkg::OFFSET_BITS_DEF;
    localparam int          OUT_W        = pcw_pkg::OUT_OFS_BITS;
    localparam logic [31:0] MAX_LEN      = 32'h7FFF_FFFF;
    localparam logic [63:0] PNG_MAGIC    = 64'h8950_4E47_0D0A_1A0A;
    localparam int          SETTLE       = 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          NCASES       = 25;
    localparam int          PHASE_WORDS  = 80;
    localparam int          PHASE_FILES  = 3;
    localparam int          TX_GAP [4]   = '{0, 51, 0, 6};
    localparam int          RX_STALL [4] = '{0, 0, 51, 6};
    localparam logic        PH_FLAG [4]  = '{1'b1, 1'b0, 1'b1, 1'b0};
    localparam pcw_pkg::t_result NO_RES  = '0;

    // one directed file: signature, one chunk cut anywhere, optional iend, trailing bytes
    typedef struct {
        logic             flag;
        int               sig_n;
        int               len_n;
        logic [31:0]      clen;
        int               type_n;
        logic [31:0]      ctype;
        int               data_n;
        logic [63:0]      dims;
        int               crc_n;
        bit               add_iend;
        int               tail;
        bit               known;
        pcw_pkg::t_result res;
    } t_case;

    typedef struct {
        bit               known;
        pcw_pkg::t_result res;
    } t_rule;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;               // [7:0] data_byte
    logic        s_axis_tuser  = pcw_pkg::KIND_BYTE;  // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;            // [2:0] outcome, [3] detected, [4] overlay_present,
                                          // [44:5] overlay_offset, [84:45] overlay_length
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data    = 1'b0;

    // walker state mirror
    pcw_pkg::t_phase   walk_phase;
    logic [3:0]        walk_count;
    logic [31:0]       walk_len;
    logic [30:0]       walk_left;
    logic [31:0]       walk_type;
    logic [63:0]       walk_dims;
    logic [OFS_W-1:0]  walk_ofs;
    pcw_pkg::t_outcome walk_stop_code;
    logic [OFS_W-1:0]  walk_stop_ofs;
    logic              walk_flag;

    pcw_pkg::t_result pending_reports [$];
    t_rule            report_rules [$];
    logic [7:0]       file_bytes [$];
    t_case            dir_cases [NCASES];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int reports_seen = 0;
    int files_fed    = 0;
    int words_fed    = 0;
    int outcome_seen [8];
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int hold_ticket  = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    logic cur_flag   = 1'b0;
    t_rule  eof_rule;

    png_chunk_walker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------- walker prediction ----------------

    function automatic void walk_clear();
        walk_phase     = pcw_pkg::PH_SIG;
        walk_count     = '0;
        walk_len       = '0;
        walk_left      = '0;
        walk_type      = '0;
        walk_dims      = '0;
        walk_ofs       = '0;
        walk_stop_code = pcw_pkg::OC_EOF;
        walk_stop_ofs  = OFS_W'(pcw_pkg::SIG_LEN);
    endfunction

    function automatic void walk_halt(pcw_pkg::t_outcome code);
        walk_stop_code = code;
        walk_phase     = pcw_pkg::PH_DONE;
    endfunction

    // end of chunk data: ihdr gets its length and dimensions checked
    function automatic void walk_data_done();
        logic [31:0] wd;
        logic [31:0] ht;
        wd = walk_dims[63:32];
        ht = walk_dims[31:0];
        if (walk_type == pcw_pkg::TYPE_IHDR && walk_len != pcw_pkg::IHDR_LEN) begin
            walk_halt(pcw_pkg::OC_BAD_IHDR_LEN);
        end else if (walk_type == pcw_pkg::TYPE_IHDR &&
                     (wd == 0 || ht == 0 || wd > MAX_LEN || ht > MAX_LEN)) begin
            walk_halt(pcw_pkg::OC_BAD_DIMS);
        end else begin
            walk_phase = pcw_pkg::PH_CRC;
            walk_count = '0;
        end
    endfunction

    function automatic void walk_byte(logic [7:0] b);
        if (walk_ofs != '1)
            walk_ofs = walk_ofs + 1'b1;
        case (walk_phase)
            pcw_pkg::PH_SIG: begin
                walk_count = walk_count + 1'b1;
                if (walk_count >= pcw_pkg::SIG_LEN) begin
                    walk_phase = pcw_pkg::PH_LEN;
                    walk_count = '0;
                    walk_len   = '0;
                end
            end
            pcw_pkg::PH_LEN: begin
                walk_len   = {walk_len[23:0], b};
                walk_count = walk_count + 1'b1;
                if (walk_count >= 4) begin
                    walk_stop_ofs = walk_ofs;
                    walk_count    = '0;
                    if (walk_len > MAX_LEN) begin
                        walk_halt(pcw_pkg::OC_LEN_TOO_BIG);
                    end else begin
                        walk_left  = walk_len[30:0];
                        walk_type  = '0;
                        walk_phase = pcw_pkg::PH_TYPE;
                    end
                end
            end
            pcw_pkg::PH_TYPE: begin
                walk_type  = {walk_type[23:0], b};
                walk_count = walk_count + 1'b1;
                if (walk_count >= 4) begin
                    walk_stop_ofs = walk_ofs;
                    walk_count    = '0;
                    walk_dims     = '0;
                    if (walk_len == 0)
                        walk_data_done();
                    else
                        walk_phase = pcw_pkg::PH_DATA;
                end
            end
            pcw_pkg::PH_DATA: begin
                // width and height sit in the first eight data bytes
                if (walk_len - {1'b0, walk_left} < 8)
                    walk_dims = {walk_dims[55:0], b};
                walk_left = walk_left - 1'b1;
                if (walk_left == 0) begin
                    walk_stop_ofs = walk_ofs;
                    walk_data_done();
                end
            end
            pcw_pkg::PH_CRC: begin
                walk_count = walk_count + 1'b1;
                if (walk_count >= 4) begin
                    walk_stop_ofs = walk_ofs;
                    walk_count    = '0;
                    if (walk_type == pcw_pkg::TYPE_IEND) begin
                        walk_halt(pcw_pkg::OC_IEND);
                    end else begin
                        walk_phase = pcw_pkg::PH_LEN;
                        walk_len   = '0;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // end of file: build the report and start over
    function automatic pcw_pkg::t_result walk_report();
        pcw_pkg::t_result  r;
        pcw_pkg::t_outcome code;
        logic              det;
        case (walk_phase)
            pcw_pkg::PH_TYPE: code = pcw_pkg::OC_EOF_TYPE;
            pcw_pkg::PH_DATA: code = pcw_pkg::OC_EOF_DATA;
            pcw_pkg::PH_CRC:  code = pcw_pkg::OC_EOF_CRC;
            pcw_pkg::PH_DONE: code = walk_stop_code;
            default:          code = pcw_pkg::OC_EOF;
        endcase
        det                 = (code >= pcw_pkg::OC_LEN_TOO_BIG) && walk_flag;
        r.outcome           = code;
        r.detected          = det;
        r.overlay_present   = !det && (walk_ofs > walk_stop_ofs);
        r.overlay_offset    = OUT_W'(walk_stop_ofs);
        r.overlay_length    = r.overlay_present ? OUT_W'(walk_ofs - walk_stop_ofs) : '0;
        walk_clear();
        return r;
    endfunction

    function automatic pcw_pkg::t_result mk_res(pcw_pkg::t_outcome code, logic det,
                                                logic pres, longint unsigned ofs,
                                                longint unsigned len);
        pcw_pkg::t_result r;
        r.outcome         = code;
        r.detected        = det;
        r.overlay_present = pres;
        r.overlay_offset  = OUT_W'(ofs);
        r.overlay_length  = OUT_W'(len);
        return r;
    endfunction

    // ---------------- report checking ----------------

    task automatic check_report(input pcw_pkg::t_result got);
        pcw_pkg::t_result want;
        if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("report with none pending: outcome %0d offset %0d length %0d",
                         got.outcome, got.overlay_offset, got.overlay_length);
        end else begin
            want = pending_reports.pop_front();
            outcome_seen[want.outcome]++;
            if (got.outcome !== want.outcome || got.detected !== want.detected ||
                got.overlay_present !== want.overlay_present ||
                got.overlay_offset !== want.overlay_offset ||
                got.overlay_length !== want.overlay_length) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("report %0d (expected/actual): outcome %0d/%0d detected %0d/%0d ",
                           reports_seen, want.outcome, got.outcome,
                           want.detected, got.detected);
                    $display("present %0d/%0d offset %0d/%0d length %0d/%0d",
                             want.overlay_present, got.overlay_present,
                             want.overlay_offset, got.overlay_offset,
                             want.overlay_length, got.overlay_length);
                end
            end
        end
        reports_seen++;
    endtask

    // monitor: config, reports, input words, and the no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                walk_flag    = i_cfg_data;
                quiet_cycles = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_report(m_axis_tdata[84:0]);
                quiet_cycles = 0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                quiet_cycles = 0;
                if (s_axis_tuser == pcw_pkg::KIND_EOF) begin
                    eof_rule = report_rules.pop_front();
                    if (eof_rule.known) begin
                        void'(walk_report());
                        pending_reports.push_back(eof_rule.res);
                    end else begin
                        pending_reports.push_back(walk_report());
                    end
                end else begin
                    walk_byte(s_axis_tdata);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------- stimulus ----------------

    function automatic void put_word(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[31-8*i -: 8]);
    endfunction

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(6))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return MAX_LEN;
            3:       return 32'h8000_0000;
            4:       return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic push_word(input logic k, input logic [7:0] b);
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= k;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_file(input bit known, input pcw_pkg::t_result res);
        t_rule r;
        foreach (file_bytes[i])
            push_word(pcw_pkg::KIND_BYTE, file_bytes[i]);
        r.known = known;
        r.res   = res;
        report_rules.push_back(r);
        push_word(pcw_pkg::KIND_EOF, 8'($urandom));
        words_fed += file_bytes.size() + 1;
        files_fed++;
    endtask

    // wait until every report is back and the block has gone quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_flag(input logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_flag = v;
    endtask

    task automatic build_case(input t_case c);
        file_bytes.delete();
        for (int i = 0; i < c.sig_n; i++)
            file_bytes.push_back(PNG_MAGIC[63-8*i -: 8]);
        put_word(c.clen, c.len_n);
        put_word(c.ctype, c.type_n);
        for (int i = 0; i < c.data_n; i++)
            file_bytes.push_back(i < 8 ? c.dims[63-8*i -: 8] : 8'hFF);
        repeat (c.crc_n) file_bytes.push_back(8'hFF);
        if (c.add_iend) begin
            put_word(32'h0, 4);
            put_word(pcw_pkg::TYPE_IEND, 4);
            put_word(32'hFFFF_FFFF, 4);
        end
        repeat (c.tail) file_bytes.push_back(8'h00);
    endtask

    // mostly well-formed files with random content, some noise, some cut short
    task automatic make_random_file();
        int          n;
        int          sel;
        logic [31:0] clen;
        logic [31:0] ctype;
        logic [63:0] dims;
        file_bytes.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(40)) file_bytes.push_back(8'($urandom));
        end else begin
            repeat (pcw_pkg::SIG_LEN) file_bytes.push_back(8'($urandom));
            n = $urandom_range(3);
            for (int c = 0; c < n; c++) begin
                sel   = $urandom_range(99);
                dims  = {pick_dim(), pick_dim()};
                ctype = $urandom;
                clen  = $urandom_range(8);
                if (sel < 30) begin
                    ctype = pcw_pkg::TYPE_IHDR;
                    clen  = ($urandom_range(99) < 80) ? pcw_pkg::IHDR_LEN :
                                                        32'($urandom_range(20));
                end else if (sel < 40) begin
                    case ($urandom_range(3))
                        0:       clen = 32'h8000_0000;
                        1:       clen = 32'hFFFF_FFFF;
                        2:       clen = MAX_LEN;
                        default: clen = $urandom | 32'h8000_0000;
                    endcase
                end else if (sel < 55) begin
                    // one bit away from a type that matters
                    ctype = ($urandom_range(1) ? pcw_pkg::TYPE_IHDR : pcw_pkg::TYPE_IEND) ^
                            (32'd1 << $urandom_range(31));
                end
                put_word(clen, 4);
                put_word(ctype, 4);
                if (sel >= 30 && sel < 40) begin
                    repeat ($urandom_range(6)) file_bytes.push_back(8'($urandom));
                    break;
                end
                for (int i = 0; i < int'(clen); i++)
                    file_bytes.push_back(i < 8 ? dims[63-8*i -: 8] : 8'($urandom));
                put_word($urandom, 4);
            end
            if ($urandom_range(99) < 70) begin
                put_word(32'h0, 4);
                put_word(pcw_pkg::TYPE_IEND, 4);
                put_word($urandom, 4);
            end
            repeat ($urandom_range(6)) file_bytes.push_back(8'($urandom));
        end
        // cut the file anywhere
        if ($urandom_range(99) < 35) begin
            n = $urandom_range(file_bytes.size());
            while (file_bytes.size() > n)
                void'(file_bytes.pop_back());
        end
    endtask

    // ---------------- main sequence ----------------

    initial begin
        int ph_words;
        int ph_files;

        // flag, sig, len bytes, length, type bytes, type, data bytes, dims, crc bytes,
        // iend, tail, known, report
        dir_cases[0]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF, 0, 0, 8, 0)};
        dir_cases[1]  = '{0, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF, 0, 0, 8, 0)};
        dir_cases[2]  = '{1, 8, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF, 0, 0, 8, 0)};
        dir_cases[3]  = '{1, 8, 2, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF, 0, 1, 8, 2)};
        dir_cases[4]  = '{1, 8, 4, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 3, 1,
                          mk_res(pcw_pkg::OC_LEN_TOO_BIG, 1, 0, 12, 0)};
        dir_cases[5]  = '{0, 8, 4, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 3, 1,
                          mk_res(pcw_pkg::OC_LEN_TOO_BIG, 0, 1, 12, 3)};
        dir_cases[6]  = '{0, 8, 4, MAX_LEN, 4, 32'h6162_6364, 2, 0, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF_DATA, 0, 1, 16, 2)};
        dir_cases[7]  = '{1, 8, 4, 5, 2, 32'h6162_6364, 0, 0, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF_TYPE, 1, 0, 12, 0)};
        dir_cases[8]  = '{0, 8, 4, 5, 2, 32'h6162_6364, 0, 0, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF_TYPE, 0, 1, 12, 2)};
        dir_cases[9]  = '{1, 8, 4, 5, 4, 32'h6162_6364, 3, 0, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF_DATA, 1, 0, 16, 0)};
        dir_cases[10] = '{1, 8, 4, 0, 4, 32'h6162_6364, 0, 0, 2, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF_CRC, 1, 0, 16, 0)};
        dir_cases[11] = '{0, 8, 4, 0, 4, 32'h6162_6364, 0, 0, 2, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF_CRC, 0, 1, 16, 2)};
        dir_cases[12] = '{1, 8, 4, 0, 4, 32'h6162_6364, 0, 0, 4, 0, 0, 1,
                          mk_res(pcw_pkg::OC_EOF, 0, 0, 20, 0)};
        dir_cases[13] = '{1, 8, 4, 0, 4, pcw_pkg::TYPE_IEND, 0, 0, 4, 0, 0, 1,
                          mk_res(pcw_pkg::OC_IEND, 0, 0, 20, 0)};
        dir_cases[14] = '{0, 8, 4, 0, 4, pcw_pkg::TYPE_IEND, 0, 0, 4, 0, 5, 1,
                          mk_res(pcw_pkg::OC_IEND, 0, 1, 20, 5)};
        dir_cases[15] = '{0, 8, 4, 0, 4, pcw_pkg::TYPE_IHDR, 0, 0, 0, 0, 2, 1,
                          mk_res(pcw_pkg::OC_BAD_IHDR_LEN, 0, 1, 16, 2)};
        dir_cases[16] = '{0, 8, 4, 12, 4, pcw_pkg::TYPE_IHDR,
                          12, {32'd1, 32'd1}, 4, 0, 0, 1,
                          mk_res(pcw_pkg::OC_BAD_IHDR_LEN, 0, 1, 28, 4)};
        dir_cases[17] = '{0, 8, 4, 14, 4, pcw_pkg::TYPE_IHDR,
                          14, {32'd1, 32'd1}, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_BAD_IHDR_LEN, 0, 0, 30, 0)};
        dir_cases[18] = '{0, 8, 4, 13, 4, pcw_pkg::TYPE_IHDR,
                          13, {32'd0, 32'd1}, 4, 0, 0, 1,
                          mk_res(pcw_pkg::OC_BAD_DIMS, 0, 1, 29, 4)};
        dir_cases[19] = '{0, 8, 4, 13, 4, pcw_pkg::TYPE_IHDR,
                          13, {32'd1, 32'd0}, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_BAD_DIMS, 0, 0, 29, 0)};
        dir_cases[20] = '{1, 8, 4, 13, 4, pcw_pkg::TYPE_IHDR,
                          13, {32'h8000_0000, 32'd1}, 4, 0, 0, 1,
                          mk_res(pcw_pkg::OC_BAD_DIMS, 0, 1, 29, 4)};
        dir_cases[21] = '{1, 8, 4, 13, 4, pcw_pkg::TYPE_IHDR,
                          13, {32'd1, 32'hFFFF_FFFF}, 0, 0, 0, 1,
                          mk_res(pcw_pkg::OC_BAD_DIMS, 0, 0, 29, 0)};
        dir_cases[22] = '{0, 8, 4, 13, 4, pcw_pkg::TYPE_IHDR,
                          13, {MAX_LEN, MAX_LEN}, 4, 1, 1, 1,
                          mk_res(pcw_pkg::OC_IEND, 0, 1, 45, 1)};
        // near misses on the type words
        dir_cases[23] = '{0, 8, 4, 12, 4, 32'h4948_4451, 12, 0, 4, 1, 0, 0, NO_RES};
        dir_cases[24] = '{1, 8, 4, 0, 4, 32'h4945_4E64, 0, 0, 4, 0, 2, 1,
                          mk_res(pcw_pkg::OC_EOF, 0, 1, 20, 2)};

        foreach (outcome_seen[i])
            outcome_seen[i] = 0;
        walk_clear();
        walk_flag = 1'b0;

        // synchronous reset, held before release
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed files, flag changed only between files
        for (int i = 0; i < NCASES; i++) begin
            if (dir_cases[i].flag != cur_flag) begin
                settle();
                write_flag(dir_cases[i].flag);
            end
            build_case(dir_cases[i]);
            send_file(dir_cases[i].known, dir_cases[i].res);
        end

        // random files under each idle and stall mix
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            write_flag(PH_FLAG[ph]);
            tx_gap_pct = TX_GAP[ph];
            rx_stall_pct <= RX_STALL[ph];
            ph_words = 0;
            ph_files = 0;
            while (ph_words < PHASE_WORDS || ph_files < PHASE_FILES) begin
                // long receiver hold-off while files keep coming
                if (ph == 0 && ph_files == 0)
                    hold_ticket <= hold_ticket + 1;
                make_random_file();
                ph_words += file_bytes.size() + 1;
                ph_files++;
                send_file(1'b0, NO_RES);
            end
        end

        settle();
        $display("run covered %0d files in %0d words, flag on and off, four idle/stall mixes",
                 files_fed, words_fed);
        $display("reports per outcome 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
                 outcome_seen[4], outcome_seen[5], outcome_seen[6], outcome_seen[7]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
